// ----- rtl/core/cdp_pkg.sv -----
`timescale 1ns / 1ps

package cdp_pkg;

    localparam int CHAR_W = 8;
    localparam int TYPE_W = 3;
    localparam int MAG_W  = 64;
    localparam int ERR_W  = 2;
    localparam int DIG_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [TYPE_W-1:0] TYPE_INT32  = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_UINT32 = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_INT64  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_UINT64 = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_U8     = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TEXT  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              is_last;
        logic [TYPE_W-1:0] value_type;
    } char_item_t;

    // what is left of a text once its last character has gone through
    typedef struct packed {
        logic [TYPE_W-1:0] value_type;
        logic              text_bad;
        logic              digit_seen;
        logic              minus_seen;
        logic              overflowed;
        logic [MAG_W-1:0]  magnitude;
    } text_sum_t;

    // packed so that ok lands in the lowest bit
    typedef struct packed {
        logic [MAG_W-1:0] value_bits;
        logic [ERR_W-1:0] error_code;
        logic             ok;
    } parse_result_t;

    function automatic logic type_is_signed(input logic [TYPE_W-1:0] t);
        return (t == TYPE_INT32) || (t == TYPE_INT64);
    endfunction

endpackage

// ----- rtl/core/canonical_decimal_integer_parser_unit.sv -----
`timescale 1ns / 1ps

// channel   dir  ports                    tdata / tuser (low bit up)
// s_        in   tvalid tready tdata      tdata: char_code[7:0]
//                tuser tlast              tuser: has_char, value_type[2:0]; tlast: is_last
// m_        out  tvalid tready tdata      tdata: ok, error_code[1:0], value_bits[63:0], 5 zero
//
// one item per cycle in steady state while m_tready stays high; a result passes in turn through
// the input register, accumulate register and range-check register once its last item is accepted
// the 64-bit multiply-by-ten and add of the accumulator sets the cycle time
// reset clears all valid flags and the per-text state; no clearing pass
// each stage stalls only when full and its successor is stalled

module canonical_decimal_integer_parser_unit
    import cdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic [3:0]  s_tuser,   // has_char, value_type
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // ok, error_code, value_bits, zero pad
);

    char_item_t    in_item;
    char_item_t    q_item;
    logic          q_valid;
    logic          q_ready;
    text_sum_t     sum;
    logic          sum_valid;
    logic          sum_ready;
    parse_result_t res;

    assign in_item = '{char_code: s_tdata, has_char: s_tuser[0], is_last: s_tlast,
                       value_type: s_tuser[3:1]};

    cdp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_item  (in_item),
        .dn_valid (q_valid),
        .dn_ready (q_ready),
        .dn_item  (q_item)
    );

    cdp_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_valid  (q_valid),
        .up_ready  (q_ready),
        .up_item   (q_item),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum)
    );

    cdp_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'b00000, res};

endmodule

// ----- rtl/core/cdp_in_stage.sv -----
`timescale 1ns / 1ps

module cdp_in_stage
    import cdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       up_valid,
    output logic       up_ready,
    input  char_item_t up_item,
    output logic       dn_valid,
    input  logic       dn_ready,
    output char_item_t dn_item
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    char_item_t item_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready) begin
            valid_next = up_valid;
            item_next  = up_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ----- rtl/core/cdp_accum.sv -----
`timescale 1ns / 1ps

module cdp_accum
    import cdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       up_valid,
    output logic       up_ready,
    input  char_item_t up_item,
    output logic       sum_valid,
    input  logic       sum_ready,
    output text_sum_t  sum
);

    logic              at_start_reg,     at_start_next;
    logic              minus_seen_reg,   minus_seen_next;
    logic              digit_seen_reg,   digit_seen_next;
    logic              leading_zero_reg, leading_zero_next;
    logic              text_bad_reg,     text_bad_next;
    logic              overflowed_reg,   overflowed_next;
    logic [MAG_W-1:0]  magnitude_reg,    magnitude_next;
    logic [TYPE_W-1:0] held_type_reg,    held_type_next;
    logic              sum_valid_reg,    sum_valid_next;
    text_sum_t         sum_reg,          sum_next;

    logic              take;
    logic [TYPE_W-1:0] cur_type;
    logic              is_minus;
    logic              is_digit;
    logic [DIG_W-1:0]  digit;
    logic [MAG_W+3:0]  mag_wide;
    logic [MAG_W+3:0]  prod;

    // updated text state before the end-of-text clear
    logic              upd_minus;
    logic              upd_digit;
    logic              upd_lz;
    logic              upd_bad;
    logic              upd_ovf;
    logic [MAG_W-1:0]  upd_mag;

    assign up_ready = !sum_valid_reg || sum_ready;
    assign take     = up_valid && up_ready;

    assign cur_type = at_start_reg ? up_item.value_type : held_type_reg;
    assign is_minus = up_item.char_code == CHAR_MINUS;
    assign is_digit = (up_item.char_code >= CHAR_ZERO) && (up_item.char_code <= CHAR_NINE);
    // the low nibble of an ascii digit is its value
    assign digit    = up_item.char_code[DIG_W-1:0];

    // magnitude * 10 + digit, carries above 64 bits mean overflow
    assign mag_wide = {4'b0000, magnitude_reg};
    assign prod     = (mag_wide << 3) + (mag_wide << 1) + {{MAG_W{1'b0}}, digit};

    always_comb begin
        upd_minus = minus_seen_reg;
        upd_digit = digit_seen_reg;
        upd_lz    = leading_zero_reg;
        upd_bad   = text_bad_reg;
        upd_ovf   = overflowed_reg;
        upd_mag   = magnitude_reg;
        if (up_item.has_char && !text_bad_reg) begin
            priority if (is_minus) begin
                if (minus_seen_reg || digit_seen_reg || !type_is_signed(cur_type)) begin
                    upd_bad = 1'b1;
                end else begin
                    upd_minus = 1'b1;
                end
            end else if (is_digit) begin
                if (leading_zero_reg) begin
                    upd_bad = 1'b1;
                end else begin
                    if (!digit_seen_reg && (digit == '0)) begin
                        upd_lz = 1'b1;
                    end
                    upd_digit = 1'b1;
                    upd_ovf   = overflowed_reg || (|prod[MAG_W+3:MAG_W]);
                    upd_mag   = prod[MAG_W-1:0];
                end
            end else begin
                upd_bad = 1'b1;
            end
        end
    end

    always_comb begin
        at_start_next     = at_start_reg;
        minus_seen_next   = minus_seen_reg;
        digit_seen_next   = digit_seen_reg;
        leading_zero_next = leading_zero_reg;
        text_bad_next     = text_bad_reg;
        overflowed_next   = overflowed_reg;
        magnitude_next    = magnitude_reg;
        held_type_next    = held_type_reg;
        sum_next          = sum_reg;
        sum_valid_next    = sum_valid_reg && !sum_ready;

        if (take) begin
            held_type_next = cur_type;
            if (up_item.is_last) begin
                sum_valid_next    = 1'b1;
                sum_next          = '{value_type: cur_type, text_bad: upd_bad,
                                      digit_seen: upd_digit, minus_seen: upd_minus,
                                      overflowed: upd_ovf, magnitude: upd_mag};
                at_start_next     = 1'b1;
                minus_seen_next   = 1'b0;
                digit_seen_next   = 1'b0;
                leading_zero_next = 1'b0;
                text_bad_next     = 1'b0;
                overflowed_next   = 1'b0;
                magnitude_next    = '0;
            end else begin
                at_start_next     = 1'b0;
                minus_seen_next   = upd_minus;
                digit_seen_next   = upd_digit;
                leading_zero_next = upd_lz;
                text_bad_next     = upd_bad;
                overflowed_next   = upd_ovf;
                magnitude_next    = upd_mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg     <= 1'b1;
            minus_seen_reg   <= 1'b0;
            digit_seen_reg   <= 1'b0;
            leading_zero_reg <= 1'b0;
            text_bad_reg     <= 1'b0;
            overflowed_reg   <= 1'b0;
            magnitude_reg    <= '0;
            held_type_reg    <= '0;
            sum_valid_reg    <= 1'b0;
        end else begin
            at_start_reg     <= at_start_next;
            minus_seen_reg   <= minus_seen_next;
            digit_seen_reg   <= digit_seen_next;
            leading_zero_reg <= leading_zero_next;
            text_bad_reg     <= text_bad_next;
            overflowed_reg   <= overflowed_next;
            magnitude_reg    <= magnitude_next;
            held_type_reg    <= held_type_next;
            sum_valid_reg    <= sum_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

`ifndef SYNTHESIS
    a_no_digit_no_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        !digit_seen_reg |-> (magnitude_reg == '0) && !overflowed_reg)
        else $error("magnitude moved without a digit");

    a_lead_zero_state: assert property (@(posedge aclk) disable iff (!aresetn)
        leading_zero_reg |-> digit_seen_reg && (magnitude_reg == '0))
        else $error("leading zero flag with nonzero magnitude");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && up_item.is_last) |=> at_start_reg && !digit_seen_reg && !text_bad_reg
            && sum_valid_reg)
        else $error("text state not cleared after last item");
`endif

endmodule

// ----- rtl/core/cdp_finish.sv -----
`timescale 1ns / 1ps

module cdp_finish
    import cdp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          sum_valid,
    output logic          sum_ready,
    input  text_sum_t     sum,
    output logic          res_valid,
    input  logic          res_ready,
    output parse_result_t res
);

    logic          valid_reg;
    logic          valid_next;
    parse_result_t res_reg;
    parse_result_t res_next;

    logic [MAG_W-1:0] limit;
    logic [MAG_W-1:0] negated;
    logic [ERR_W-1:0] err;
    logic             take;

    assign sum_ready = !valid_reg || res_ready;
    assign take      = sum_valid && sum_ready;

    always_comb begin
        unique case (sum.value_type)
            TYPE_INT32:  limit = sum.minus_seen ? 64'h0000_0000_8000_0000
                                                : 64'h0000_0000_7FFF_FFFF;
            TYPE_UINT32: limit = 64'h0000_0000_FFFF_FFFF;
            TYPE_INT64:  limit = sum.minus_seen ? 64'h8000_0000_0000_0000
                                                : 64'h7FFF_FFFF_FFFF_FFFF;
            TYPE_UINT64: limit = 64'hFFFF_FFFF_FFFF_FFFF;
            default:     limit = 64'h0000_0000_0000_00FF;
        endcase
    end

    assign negated = '0 - sum.magnitude;

    // text errors win over range errors
    always_comb begin
        priority if ((sum.value_type > TYPE_U8) || sum.text_bad || !sum.digit_seen) begin
            err = ERR_TEXT;
        end else if (sum.overflowed || (sum.magnitude > limit)) begin
            err = ERR_RANGE;
        end else begin
            err = ERR_NONE;
        end
    end

    always_comb begin
        valid_next = valid_reg && !res_ready;
        res_next   = res_reg;
        if (take) begin
            valid_next          = 1'b1;
            res_next.ok         = err == ERR_NONE;
            res_next.error_code = err;
            if (err != ERR_NONE) begin
                res_next.value_bits = '0;
            end else begin
                res_next.value_bits = sum.minus_seen ? negated : sum.magnitude;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_fail_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !res_reg.ok) |-> (res_reg.value_bits == '0)
            && (res_reg.error_code != ERR_NONE))
        else $error("failed result carries a value");
`endif

endmodule
